// ===== hw/rtl/crg_pkg.sv =====
// shared types and constants for the camera ray generator
package crg_pkg;

    localparam int unsigned NORM_BITS = 28;
    localparam int unsigned SQ_BITS   = 2 * NORM_BITS + 2;
    localparam int unsigned ROOT_BITS = NORM_BITS + 1;
    localparam int unsigned Q_BITS    = 15;
    localparam int unsigned NUM_SQRT  = ROOT_BITS;
    localparam int unsigned NUM_DIV   = Q_BITS;

    localparam logic [2:0] REG_LOOK   = 3'd0;
    localparam logic [2:0] REG_RIGHT  = 3'd1;
    localparam logic [2:0] REG_UP     = 3'd2;
    localparam logic [2:0] REG_POS    = 3'd3;
    localparam logic [2:0] REG_WIDTH  = 3'd4;
    localparam logic [2:0] REG_HEIGHT = 3'd5;
    localparam logic [2:0] REG_DEPTH  = 3'd6;

    typedef struct packed {
        logic [47:0] look;
        logic [47:0] right;
        logic [47:0] up;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] depth;
    } t_cfg;

    typedef struct packed {
        logic [2:0][NORM_BITS-1:0] mag;
        logic [2:0]                neg;
        logic                      degen;
        logic [SQ_BITS-1:0]        s;
        logic [ROOT_BITS-1:0]      root;
        logic [ROOT_BITS+1:0]      rem;
    } t_sq;

    typedef struct packed {
        logic [2:0][Q_BITS-1:0]    nlo;
        logic [2:0][ROOT_BITS+1:0] rem;
        logic [2:0][Q_BITS-1:0]    q;
        logic [ROOT_BITS:0]        dv;
        logic [2:0]                neg;
        logic                      degen;
    } t_dv;

endpackage

// ===== hw/rtl/crg_front.sv =====
// front pipeline: direction products, sum, block normalization, sum of squares
module crg_front
    import crg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [14:0] i_offset_x,
    input  logic [14:0] i_offset_y,
    output logic        o_valid,
    input  logic        i_ready,
    output t_sq         o_sq
);

    localparam int unsigned NST = 7;

    logic [NST-1:0] r_v;
    logic [NST-1:0] st_rdy;

    always_comb begin
        st_rdy[NST-1] = ~r_v[NST-1] | i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            st_rdy[k] = ~r_v[k] | st_rdy[k+1];
        end
    end

    assign o_ready = st_rdy[0];
    assign o_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (st_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (st_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: offset scaling and depth term
    logic signed [31:0]       r_sx, r_sy;
    logic signed [2:0][32:0]  r_dl;
    logic signed [31:0]       n_sx, n_sy;
    logic signed [2:0][32:0]  n_dl;

    always_comb begin
        logic signed [14:0] ox, oy;
        logic signed [16:0] w, h, d;
        logic signed [15:0] lk;
        ox = i_offset_x;
        oy = i_offset_y;
        w  = {1'b0, i_cfg.width};
        h  = {1'b0, i_cfg.height};
        d  = {1'b0, i_cfg.depth};
        n_sx = ox * w;
        n_sy = oy * h;
        for (int i = 0; i < 3; i++) begin
            lk = i_cfg.look[16*i +: 16];
            n_dl[i] = lk * d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && st_rdy[0]) begin
            r_sx <= n_sx;
            r_sy <= n_sy;
            r_dl <= n_dl;
        end
    end

    // stage 2: basis products
    logic signed [2:0][47:0] r_pl, r_pr, r_pu;
    logic signed [2:0][47:0] n_pl, n_pr, n_pu;

    always_comb begin
        logic signed [15:0] rc, uc;
        for (int i = 0; i < 3; i++) begin
            rc = i_cfg.right[16*i +: 16];
            uc = i_cfg.up[16*i +: 16];
            n_pl[i] = 48'($signed(r_dl[i])) <<< 14;
            n_pr[i] = rc * r_sx;
            n_pu[i] = uc * r_sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v[0] && st_rdy[1]) begin
            r_pl <= n_pl;
            r_pr <= n_pr;
            r_pu <= n_pu;
        end
    end

    // stage 3: sum and magnitude
    logic [2:0][46:0] r_m3, n_m3;
    logic [2:0]       r_neg3, n_neg3;

    always_comb begin
        logic signed [47:0] dsum;
        for (int i = 0; i < 3; i++) begin
            dsum = r_pl[i] + r_pr[i] + r_pu[i];
            n_neg3[i] = dsum[47];
            n_m3[i]   = dsum[47] ? 47'(-dsum) : dsum[46:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v[1] && st_rdy[2]) begin
            r_m3   <= n_m3;
            r_neg3 <= n_neg3;
        end
    end

    // stage 4: bit length of the largest magnitude
    logic [2:0][46:0] r_m4;
    logic [2:0]       r_neg4;
    logic [5:0]       r_b4, n_b4;

    always_comb begin
        logic [46:0] orv;
        orv  = r_m3[0] | r_m3[1] | r_m3[2];
        n_b4 = '0;
        for (int k = 0; k < 47; k++) begin
            if (orv[k]) begin
                n_b4 = 6'(k + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v[2] && st_rdy[3]) begin
            r_m4   <= r_m3;
            r_neg4 <= r_neg3;
            r_b4   <= n_b4;
        end
    end

    // stage 5: block shift to NORM_BITS
    logic [2:0][NORM_BITS-1:0] r_m5, n_m5;
    logic [2:0]                r_neg5;
    logic                      r_dg5;

    always_comb begin
        logic [46:0] sh;
        for (int i = 0; i < 3; i++) begin
            if (r_b4 > 6'(NORM_BITS)) begin
                sh = r_m4[i] >> (r_b4 - 6'(NORM_BITS));
            end else begin
                sh = r_m4[i] << (6'(NORM_BITS) - r_b4);
            end
            n_m5[i] = sh[NORM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v[3] && st_rdy[4]) begin
            r_m5   <= n_m5;
            r_neg5 <= r_neg4;
            r_dg5  <= (r_b4 == '0);
        end
    end

    // stage 6: squares
    logic [2:0][2*NORM_BITS-1:0] r_sq6;
    logic [2:0][NORM_BITS-1:0]   r_m6;
    logic [2:0]                  r_neg6;
    logic                        r_dg6;

    always_ff @(posedge i_clk) begin
        if (r_v[4] && st_rdy[5]) begin
            for (int i = 0; i < 3; i++) begin
                r_sq6[i] <= r_m5[i] * r_m5[i];
            end
            r_m6   <= r_m5;
            r_neg6 <= r_neg5;
            r_dg6  <= r_dg5;
        end
    end

    // stage 7: sum of squares, seeds the root chain
    t_sq r_out;

    always_ff @(posedge i_clk) begin
        if (r_v[5] && st_rdy[6]) begin
            r_out.mag   <= r_m6;
            r_out.neg   <= r_neg6;
            r_out.degen <= r_dg6;
            r_out.s     <= SQ_BITS'(r_sq6[0]) + SQ_BITS'(r_sq6[1]) + SQ_BITS'(r_sq6[2]);
            r_out.root  <= '0;
            r_out.rem   <= '0;
        end
    end

    assign o_sq = r_out;

endmodule

// ===== hw/rtl/crg_sqrt_cell.sv =====
// one root bit of the integer square root chain
module crg_sqrt_cell
    import crg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sq  i_d,
    output logic o_valid,
    input  logic i_ready,
    output t_sq  o_d
);

    logic r_v;
    t_sq  r_d, n_d;

    assign o_ready = ~r_v | i_ready;
    assign o_valid = r_v;
    assign o_d     = r_d;

    always_comb begin
        logic [ROOT_BITS+1:0] t, trial;
        n_d   = i_d;
        t     = {i_d.rem[ROOT_BITS-1:0], i_d.s[SQ_BITS-1 -: 2]};
        trial = (ROOT_BITS+2)'({i_d.root, 2'b01});
        n_d.s = i_d.s << 2;
        if (t >= trial) begin
            n_d.rem  = t - trial;
            n_d.root = {i_d.root[ROOT_BITS-2:0], 1'b1};
        end else begin
            n_d.rem  = t;
            n_d.root = {i_d.root[ROOT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_d <= n_d;
        end
    end

endmodule

// ===== hw/rtl/crg_div_cell.sv =====
// one quotient bit for all three components
module crg_div_cell
    import crg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_dv  i_d,
    output logic o_valid,
    input  logic i_ready,
    output t_dv  o_d
);

    logic r_v;
    t_dv  r_d, n_d;

    assign o_ready = ~r_v | i_ready;
    assign o_valid = r_v;
    assign o_d     = r_d;

    always_comb begin
        logic [ROOT_BITS+1:0] t, dve;
        n_d = i_d;
        dve = (ROOT_BITS+2)'(i_d.dv);
        for (int i = 0; i < 3; i++) begin
            t = {i_d.rem[i][ROOT_BITS:0], i_d.nlo[i][Q_BITS-1]};
            n_d.nlo[i] = i_d.nlo[i] << 1;
            if (t >= dve) begin
                n_d.rem[i] = t - dve;
                n_d.q[i]   = {i_d.q[i][Q_BITS-2:0], 1'b1};
            end else begin
                n_d.rem[i] = t;
                n_d.q[i]   = {i_d.q[i][Q_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_d <= n_d;
        end
    end

endmodule

// ===== hw/rtl/camera_ray_generator.sv =====
// top level: config registers, front pipeline, root and divide cell chains
//
//  channel  | signals                                  | transfer
//  ---------+------------------------------------------+---------------------------
//  input    | i_valid, o_ready, i_offset_x/y           | valid and ready high
//  output   | o_valid, i_ready, o_dir_*, o_origin_*,    | valid and ready high
//           | o_degenerate                             |
//  config   | i_cfg_we, i_cfg_index, i_cfg_data        | write enable high
//
// one transaction per cycle while the output is not stalled; the path is 7 front stages,
// 29 root cells, 15 divide cells and the output register (one bit per root or divide cell)
// every stage holds its own valid bit, so a stalled output fills the chain and
// bubbles are squeezed out; reset is synchronous, clears the valid bits and
// loads the register defaults
module camera_ray_generator
    import crg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [14:0] i_offset_x,
    input  logic [14:0] i_offset_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_dir_x,
    output logic [15:0] o_dir_y,
    output logic [15:0] o_dir_z,
    output logic [15:0] o_origin_x,
    output logic [15:0] o_origin_y,
    output logic [15:0] o_origin_z,
    output logic        o_degenerate
);

    // configuration registers
    t_cfg        r_cfg;
    logic [47:0] r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.look   <= 48'd16384;
            r_cfg.right  <= 48'd16384;
            r_cfg.up     <= 48'd16384;
            r_pos        <= '0;
            r_cfg.width  <= 16'd256;
            r_cfg.height <= 16'd256;
            r_cfg.depth  <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LOOK:   r_cfg.look   <= i_cfg_data;
                REG_RIGHT:  r_cfg.right  <= i_cfg_data;
                REG_UP:     r_cfg.up     <= i_cfg_data;
                REG_POS:    r_pos        <= i_cfg_data;
                REG_WIDTH:  r_cfg.width  <= i_cfg_data[15:0];
                REG_HEIGHT: r_cfg.height <= i_cfg_data[15:0];
                REG_DEPTH:  r_cfg.depth  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // front pipeline
    logic sq_v   [NUM_SQRT+1];
    logic sq_r   [NUM_SQRT+1];
    t_sq  sq_d   [NUM_SQRT+1];

    crg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_offset_x (i_offset_x),
        .i_offset_y (i_offset_y),
        .o_valid    (sq_v[0]),
        .i_ready    (sq_r[0]),
        .o_sq       (sq_d[0])
    );

    // square root chain, one root bit per cell
    for (genvar g = 0; g < NUM_SQRT; g++) begin : g_sqrt
        crg_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v[g]),
            .o_ready (sq_r[g]),
            .i_d     (sq_d[g]),
            .o_valid (sq_v[g+1]),
            .i_ready (sq_r[g+1]),
            .o_d     (sq_d[g+1])
        );
    end

    // divide setup: numerator m*2^15 + L, divisor 2L
    logic dv_v [NUM_DIV+1];
    logic dv_r [NUM_DIV+1];
    t_dv  dv_d [NUM_DIV+1];

    always_comb begin
        logic [NORM_BITS+Q_BITS:0] num;
        t_sq                       s;
        s = sq_d[NUM_SQRT];
        dv_d[0].dv    = {s.root, 1'b0};
        dv_d[0].neg   = s.neg;
        dv_d[0].degen = s.degen;
        dv_d[0].q     = '0;
        for (int i = 0; i < 3; i++) begin
            num = {1'b0, s.mag[i], {Q_BITS{1'b0}}} + (NORM_BITS+Q_BITS+1)'(s.root);
            dv_d[0].nlo[i] = num[Q_BITS-1:0];
            dv_d[0].rem[i] = (ROOT_BITS+2)'(num[NORM_BITS+Q_BITS:Q_BITS]);
        end
    end

    assign dv_v[0]        = sq_v[NUM_SQRT];
    assign sq_r[NUM_SQRT] = dv_r[0];

    // restoring divide chain, one quotient bit per cell
    for (genvar g = 0; g < NUM_DIV; g++) begin : g_div
        crg_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_v[g]),
            .o_ready (dv_r[g]),
            .i_d     (dv_d[g]),
            .o_valid (dv_v[g+1]),
            .i_ready (dv_r[g+1]),
            .o_d     (dv_d[g+1])
        );
    end

    // output register: sign applied, zero direction forced
    logic              r_ov;
    logic [2:0][15:0]  r_dir, n_dir;
    logic              r_dg;
    t_dv               fin;

    assign fin            = dv_d[NUM_DIV];
    assign dv_r[NUM_DIV]  = ~r_ov | i_ready;

    always_comb begin
        logic [15:0] qe;
        for (int i = 0; i < 3; i++) begin
            qe = 16'(fin.q[i]);
            if (fin.degen) begin
                n_dir[i] = '0;
            end else if (fin.neg[i]) begin
                n_dir[i] = 16'(-qe);
            end else begin
                n_dir[i] = qe;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (dv_r[NUM_DIV]) begin
            r_ov <= dv_v[NUM_DIV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (dv_r[NUM_DIV] && dv_v[NUM_DIV]) begin
            r_dir <= n_dir;
            r_dg  <= fin.degen;
        end
    end

    assign o_valid      = r_ov;
    assign o_dir_x      = r_dir[0];
    assign o_dir_y      = r_dir[1];
    assign o_dir_z      = r_dir[2];
    assign o_degenerate = r_dg;
    // the user must change position only while no transaction is in flight; the block does not enforce it
    assign o_origin_x   = r_pos[15:0];
    assign o_origin_y   = r_pos[31:16];
    assign o_origin_z   = r_pos[47:32];

endmodule

// ===== verif/camera_ray_generator_test.sv =====
// self-checking testbench for the camera ray generator with its own ray predictor
`timescale 1ns / 1ps

module camera_ray_generator_test;
    import crg_pkg::*;

    // index past the last register, writes to it must be ignored
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int         DRAIN_CYCLES = 60;    // beyond the pipeline latency
    localparam int         HOLD_CYCLES = 300;    // long receiver hold-off, fills the pipeline
    localparam int         STALE_LIMIT = 2000;   // cycles without any transaction

    typedef struct {
        logic [14:0] ox;
        logic [14:0] oy;
    } t_offset;

    typedef struct {
        logic [15:0] dir_x;
        logic [15:0] dir_y;
        logic [15:0] dir_z;
        logic [15:0] org_x;
        logic [15:0] org_y;
        logic [15:0] org_z;
        logic        degen;
    } t_ray;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [47:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [14:0] i_offset_x;
    logic [14:0] i_offset_y;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_dir_x;
    logic [15:0] o_dir_y;
    logic [15:0] o_dir_z;
    logic [15:0] o_origin_x;
    logic [15:0] o_origin_y;
    logic [15:0] o_origin_z;
    logic        o_degenerate;

    camera_ray_generator u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_offset_x   (i_offset_x),
        .i_offset_y   (i_offset_y),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_dir_x      (o_dir_x),
        .o_dir_y      (o_dir_y),
        .o_dir_z      (o_dir_z),
        .o_origin_x   (o_origin_x),
        .o_origin_y   (o_origin_y),
        .o_origin_z   (o_origin_z),
        .o_degenerate (o_degenerate)
    );

    // predictor copy of the camera setup
    logic [47:0] cam_look;
    logic [47:0] cam_right;
    logic [47:0] cam_up;
    logic [47:0] cam_pos;
    logic [15:0] cam_width;
    logic [15:0] cam_height;
    logic [15:0] cam_depth;

    t_offset pending_offsets[$];   // items waiting for the driver
    t_ray    expected_rays[$];     // predicted rays, oldest first
    int      mismatch_count;
    bit      no_idle;              // both sides run without gaps
    int      hold_req;             // bumped to ask the receiver for a long hold-off
    int      stale_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("mismatch: %s got %h expected %h", what, got, want);
    endtask

    // exact integer square root, bit-pair method
    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv >>= 2;
        while (bitv != 0) begin
            if (s >= root + bitv) begin
                s -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // unit ray direction for one film offset under the current camera setup
    function automatic t_ray trace_ray(input logic [14:0] ox, input logic [14:0] oy);
        t_ray            r;
        longint          sx;
        longint          sy;
        longint          d;
        longint          lk;
        longint          rt;
        longint          upc;
        longint unsigned mag[3];
        bit              neg[3];
        longint unsigned maxm;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        logic [15:0]     dir[3];
        int              nbits;
        sx = longint'($signed(ox)) * longint'({48'd0, cam_width});
        sy = longint'($signed(oy)) * longint'({48'd0, cam_height});
        maxm = 0;
        for (int i = 0; i < 3; i++) begin
            lk  = longint'($signed(cam_look[16*i +: 16]));
            rt  = longint'($signed(cam_right[16*i +: 16]));
            upc = longint'($signed(cam_up[16*i +: 16]));
            d = lk * longint'({48'd0, cam_depth}) * 16384 + rt * sx + upc * sy;
            neg[i] = d < 0;
            mag[i] = neg[i] ? longint'(-d) : longint'(d);
            if (mag[i] > maxm)
                maxm = mag[i];
        end
        r.degen = (maxm == 0);
        for (int i = 0; i < 3; i++)
            dir[i] = 16'd0;
        if (maxm != 0) begin
            nbits = 0;
            while ((maxm >> nbits) != 0)
                nbits++;
            sum = 0;
            // block-normalize so the largest magnitude has NORM_BITS bits
            for (int i = 0; i < 3; i++) begin
                if (nbits > NORM_BITS)
                    mag[i] >>= (nbits - NORM_BITS);
                else
                    mag[i] <<= (NORM_BITS - nbits);
                sum += mag[i] * mag[i];
            end
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++) begin
                q = (mag[i] * 32768 + len) / (2 * len);
                dir[i] = neg[i] ? 16'(16'd0 - q[15:0]) : q[15:0];
            end
        end
        r.dir_x = dir[0];
        r.dir_y = dir[1];
        r.dir_z = dir[2];
        r.org_x = cam_pos[15:0];
        r.org_y = cam_pos[31:16];
        r.org_z = cam_pos[47:32];
        return r;
    endfunction

    // driver: one offset pair per transaction, random gap drawn per item
    always @(posedge i_clk) begin : drive_p
        int      gap;
        logic    nv;
        t_offset it;
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_offset_x <= '0;
            i_offset_y <= '0;
            gap = 0;
        end else begin
            nv = i_valid;
            if (i_valid && o_ready) begin
                expected_rays.push_back(trace_ray(i_offset_x, i_offset_y));
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap > 0) begin
                    gap--;
                end else if (pending_offsets.size() != 0) begin
                    it = pending_offsets.pop_front();
                    i_offset_x <= it.ox;
                    i_offset_y <= it.oy;
                    nv = 1'b1;
                    gap = no_idle ? 0 : $urandom_range(0, 4);
                end
            end
            i_valid <= nv;
        end
    end

    // monitor: compares each ray with the oldest prediction and paces i_ready
    always @(posedge i_clk) begin : watch_p
        int   stall;
        int   hold_cnt;
        int   hold_seen;
        logic nr;
        t_ray want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall = 0;
            hold_cnt = 0;
            hold_seen = 0;
        end else begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_cnt = HOLD_CYCLES;
            end
            if (o_valid && i_ready) begin
                if (expected_rays.size() == 0) begin
                    report("unexpected ray", o_dir_x, 16'd0);
                end else begin
                    want = expected_rays.pop_front();
                    if (o_dir_x !== want.dir_x) report("dir_x", o_dir_x, want.dir_x);
                    if (o_dir_y !== want.dir_y) report("dir_y", o_dir_y, want.dir_y);
                    if (o_dir_z !== want.dir_z) report("dir_z", o_dir_z, want.dir_z);
                    if (o_origin_x !== want.org_x) report("origin_x", o_origin_x, want.org_x);
                    if (o_origin_y !== want.org_y) report("origin_y", o_origin_y, want.org_y);
                    if (o_origin_z !== want.org_z) report("origin_z", o_origin_z, want.org_z);
                    if (o_degenerate !== want.degen)
                        report("degenerate", 16'(o_degenerate), 16'(want.degen));
                end
                stall = no_idle ? 0 : $urandom_range(0, 4);
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                nr = 1'b0;
            end else if (stall > 0) begin
                stall--;
                nr = 1'b0;
            end else begin
                nr = 1'b1;
            end
            i_ready <= nr;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we)
            stale_cycles <= 0;
        else
            stale_cycles <= stale_cycles + 1;
        if (stale_cycles >= STALE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            REG_LOOK:   cam_look = value;
            REG_RIGHT:  cam_right = value;
            REG_UP:     cam_up = value;
            REG_POS:    cam_pos = value;
            REG_WIDTH:  cam_width = value[15:0];
            REG_HEIGHT: cam_height = value[15:0];
            REG_DEPTH:  cam_depth = value[15:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    function automatic logic [14:0] rand_offset();
        // mostly the nominal +-0.5 window, sometimes the full field range
        if ($urandom_range(0, 3) == 0)
            return 15'($urandom());
        return 15'($signed($urandom_range(0, 16384)) - 16384 / 2);
    endfunction

    task automatic add_offset(input logic [14:0] ox, input logic [14:0] oy);
        t_offset it;
        it.ox = ox;
        it.oy = oy;
        pending_offsets.push_back(it);
    endtask

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++)
            add_offset(rand_offset(), rand_offset());
    endtask

    task automatic wait_idle();
        while (pending_offsets.size() != 0 || i_valid || expected_rays.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_camera();
        write_reg(REG_LOOK, rand48());
        write_reg(REG_RIGHT, rand48());
        write_reg(REG_UP, rand48());
        write_reg(REG_POS, rand48());
        write_reg(REG_WIDTH, 48'($urandom()));
        write_reg(REG_HEIGHT, 48'($urandom()));
        write_reg(REG_DEPTH, 48'($urandom()));
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        mismatch_count = 0;
        no_idle = 1'b0;
        hold_req = 0;
        stale_cycles = 0;
        // reset values of the camera setup
        cam_look = 48'd16384;
        cam_right = 48'd16384;
        cam_up = 48'd16384;
        cam_pos = 48'd0;
        cam_width = 16'd256;
        cam_height = 16'd256;
        cam_depth = 16'd256;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes; at reset all basis vectors point along x,
        // so equal offsets of -0.5 cancel the depth term and give a zero direction
        add_offset(15'd0, 15'd0);
        add_offset(-15'sd8192, -15'sd8192);
        add_offset(-15'sd16384, 15'd0);
        add_offset(15'd8192, 15'd8192);
        add_offset(-15'sd8192, 15'd8192);
        add_offset(15'd8192, -15'sd8192);
        add_offset(15'h3fff, 15'h3fff);
        add_offset(15'h4000, 15'h4000);
        add_offset(15'h7fff, 15'h7fff);
        add_offset(15'h5555, 15'h2aaa);
        add_offset(15'h2aaa, 15'h5555);
        add_offset(15'd1, 15'h7fff);
        wait_idle();

        // orthogonal camera, directions off the axes
        write_reg(REG_LOOK, {16'd0, 16'd0, 16'd16384});
        write_reg(REG_RIGHT, {16'd0, 16'd16384, 16'd0});
        write_reg(REG_UP, {16'd16384, 16'd0, 16'd0});
        write_reg(REG_POS, {16'h8000, 16'h7fff, 16'h1234});
        write_reg(REG_UNUSED, rand48());
        add_offset(15'd0, 15'd0);
        add_offset(-15'sd8192, 15'd8192);
        add_offset(15'h4000, 15'h3fff);
        add_random(300);
        wait_idle();

        // register extremes: all ones, most negative and most positive components
        write_reg(REG_LOOK, {3{16'h8000}});
        write_reg(REG_RIGHT, {3{16'hffff}});
        write_reg(REG_UP, {3{16'h7fff}});
        write_reg(REG_POS, {48{1'b1}});
        write_reg(REG_WIDTH, 48'hffff);
        write_reg(REG_HEIGHT, 48'hffff);
        write_reg(REG_DEPTH, 48'hffff);
        add_offset(15'h4000, 15'h4000);
        add_offset(15'h3fff, 15'h3fff);
        add_random(250);
        wait_idle();

        // zero sizes: every ray is degenerate
        write_reg(REG_WIDTH, 48'd0);
        write_reg(REG_HEIGHT, 48'd0);
        write_reg(REG_DEPTH, 48'd0);
        add_random(30);
        wait_idle();

        // random cameras with random pacing
        random_camera();
        add_random(300);
        wait_idle();
        random_camera();
        add_random(200);
        wait_idle();

        // back-pressure: full rate sender, receiver holds off and the pipeline fills
        random_camera();
        no_idle = 1'b1;
        hold_req++;
        add_random(250);
        wait_idle();
        no_idle = 1'b0;

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
